>>> rtl/tcq_pkg.sv
// Package for the timeout callback queue: codes, widths and the structs
// that travel between the queue controller and its chain of slot cells.
// No dependencies.
package tcq_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int RESULT_CAP    = 8;
    localparam int TIME_W        = 32;
    localparam int HANDLE_W      = 16;
    localparam int CNT_W         = $clog2(RESULT_CAP + 1);

    // request command codes
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_REGISTER = 2'd1;
    localparam logic [1:0] CMD_SERVICE  = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    // register outcome codes
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NULL      = 2'd2;

    // search token handed from cell to cell
    typedef struct packed {
        logic                free_found;
        logic                exp_found;
        logic [TIME_W-1:0]   exp_over;
        logic [HANDLE_W-1:0] exp_handle;
    } t_tok;

    // slot write broadcast from the controller
    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   armed_at;
        logic [TIME_W-1:0]   deadline;
    } t_wr;

endpackage

>>> rtl/tcq_cell.sv
// One slot of the timeout queue: holds an entry and merges it into the
// search token passed along the chain. Depends on tcq_pkg.
module tcq_cell
    import tcq_pkg::*;
#(
    parameter int IW  = 3,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TIME_W-1:0] i_now,
    input  t_wr               i_wr,
    input  logic [IW-1:0]     i_wr_idx,
    input  logic              i_clr_en,
    input  logic [IW-1:0]     i_clr_idx,
    input  t_tok              i_tok,
    input  logic [IW-1:0]     i_tok_free_idx,
    input  logic [IW-1:0]     i_tok_exp_idx,
    output t_tok              o_tok,
    output logic [IW-1:0]     o_tok_free_idx,
    output logic [IW-1:0]     o_tok_exp_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                r_valid;
    logic [TIME_W-1:0]   r_req;
    logic [TIME_W-1:0]   r_dl;
    logic [HANDLE_W-1:0] r_handle;

    logic                expired;
    logic [TIME_W-1:0]   over;
    logic                take_exp;
    logic                take_free;
    t_tok                n_tok;
    logic [IW-1:0]       n_free_idx;
    logic [IW-1:0]       n_exp_idx;

    always_comb begin
        expired   = r_valid && (((r_dl <= i_now) && (r_req <= i_now)) ||
                                ((r_req >= i_now) && (i_now >= r_dl)));
        over      = i_now - r_dl;
        // strict compare: on a tie the lower slot already in the token wins
        take_exp  = expired && (!i_tok.exp_found || (over > i_tok.exp_over));
        take_free = !r_valid && !i_tok.free_found;

        n_tok            = i_tok;
        n_free_idx       = i_tok_free_idx;
        n_exp_idx        = i_tok_exp_idx;
        n_tok.free_found = i_tok.free_found | !r_valid;
        n_tok.exp_found  = i_tok.exp_found | expired;
        if (take_free) begin
            n_free_idx = MY_IDX;
        end
        if (take_exp) begin
            n_tok.exp_over   = over;
            n_tok.exp_handle = r_handle;
            n_exp_idx        = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            o_tok          <= '0;
            o_tok_free_idx <= '0;
            o_tok_exp_idx  <= '0;
        end else begin
            o_tok          <= n_tok;
            o_tok_free_idx <= n_free_idx;
            o_tok_exp_idx  <= n_exp_idx;
            if (i_wr.en && (i_wr_idx == MY_IDX)) begin
                r_valid <= 1'b1;
            end else if (i_clr_en && (i_clr_idx == MY_IDX)) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == MY_IDX)) begin
            r_req    <= i_wr.armed_at;
            r_dl     <= i_wr.deadline;
            r_handle <= i_wr.handle;
        end
    end

endmodule

>>> rtl/timeout_callback_queue_unit.sv
// Top level of the timeout callback queue: request decode, tick counter,
// result sequencing and the chain of slot cells. Depends on tcq_pkg, tcq_cell.
//
// Usage: requests enter on the slave stream (tdata = command, handle,
// delay_ticks from bit 0 up); results leave on the master stream (tuser =
// kind, tdata = status, fired_handle, tlast = final result of a request).
// A tick request advances the 32-bit time counter in the accept cycle and
// gives no result. A register request places a nonzero handle in the
// lowest free slot and answers with one status result. A service request
// frees and reports up to RESULT_CAP expired entries, largest overdue
// first, or one "nothing expired" result.
// Timing: every search lets a token run through the SLOTS cells, one cell
// per cycle. Ready is high only while no request is in work. Reset clears
// the time counter, every slot valid bit and both streams. When the
// receiver stalls, the output register holds its result and the search
// waits at its end until the register can be reloaded; no result is lost
// or repeated.
module timeout_callback_queue_unit
    import tcq_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // command[1:0], handle[17:2], delay_ticks[49:18]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // status[1:0], fired_handle[17:2]
    output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // controller registers
    t_state              r_state,      n_state;
    logic [TIME_W-1:0]   r_now,        n_now;
    logic [1:0]          r_cmd,        n_cmd;
    logic [HANDLE_W-1:0] r_handle,     n_handle;
    logic [TIME_W-1:0]   r_delay,      n_delay;
    logic [WW-1:0]       r_wait,       n_wait;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic                r_pend_valid, n_pend_valid;
    logic [HANDLE_W-1:0] r_pend_hdl,   n_pend_hdl;

    // output register
    logic                r_o_valid,    n_o_valid;
    logic [1:0]          r_o_kind,     n_o_kind;
    logic [1:0]          r_o_status,   n_o_status;
    logic [HANDLE_W-1:0] r_o_handle,   n_o_handle;
    logic                r_o_last,     n_o_last;

    // chain wiring: entry 0 is the empty token entering the first cell
    t_tok          w_tok      [SLOTS+1];
    logic [IW-1:0] w_free_idx [SLOTS+1];
    logic [IW-1:0] w_exp_idx  [SLOTS+1];

    t_wr           w_wr;
    logic [IW-1:0] w_wr_idx;
    logic          w_clr_en;
    logic [IW-1:0] w_clr_idx;

    logic          in_acc;
    logic          out_free;
    logic          scan_done;
    t_tok          tok_end;
    logic [1:0]    in_cmd;
    logic [HANDLE_W-1:0] in_handle;
    logic [TIME_W-1:0]   in_delay;

    assign w_tok[0]      = '0;
    assign w_free_idx[0] = '0;
    assign w_exp_idx[0]  = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tcq_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_now          (r_now),
            .i_wr           (w_wr),
            .i_wr_idx       (w_wr_idx),
            .i_clr_en       (w_clr_en),
            .i_clr_idx      (w_clr_idx),
            .i_tok          (w_tok[g]),
            .i_tok_free_idx (w_free_idx[g]),
            .i_tok_exp_idx  (w_exp_idx[g]),
            .o_tok          (w_tok[g+1]),
            .o_tok_free_idx (w_free_idx[g+1]),
            .o_tok_exp_idx  (w_exp_idx[g+1])
        );
    end

    assign in_cmd    = i_s_axis_tdata[1:0];
    assign in_handle = i_s_axis_tdata[17:2];
    assign in_delay  = i_s_axis_tdata[49:18];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign tok_end         = w_tok[SLOTS];
    // the token at the chain end is valid once the table has stayed still
    // while a token ran through all SLOTS cells
    assign scan_done       = (r_state == S_SCAN) && (r_wait == '0) && out_free;

    // slot write on a successful register, slot free on a fired entry
    always_comb begin
        w_wr.en       = scan_done && (r_cmd == CMD_REGISTER) &&
                        (r_handle != '0) && tok_end.free_found;
        w_wr.handle   = r_handle;
        w_wr.armed_at = r_now;
        w_wr.deadline = r_now + r_delay;
        w_wr_idx      = w_free_idx[SLOTS];
        w_clr_en      = scan_done && (r_cmd == CMD_SERVICE) && tok_end.exp_found &&
                        (r_count < CNT_W'(RESULT_CAP));
        w_clr_idx     = w_exp_idx[SLOTS];
    end

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_cmd        = r_cmd;
        n_handle     = r_handle;
        n_delay      = r_delay;
        n_wait       = r_wait;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_hdl   = r_pend_hdl;
        n_o_valid    = r_o_valid && !i_m_axis_tready;
        n_o_kind     = r_o_kind;
        n_o_status   = r_o_status;
        n_o_handle   = r_o_handle;
        n_o_last     = r_o_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == CMD_TICK) begin
                        n_now = r_now + 1'b1;
                    end else if ((in_cmd == CMD_REGISTER) || (in_cmd == CMD_SERVICE)) begin
                        n_cmd        = in_cmd;
                        n_handle     = in_handle;
                        n_delay      = in_delay;
                        n_wait       = WW'(SLOTS);
                        n_count      = '0;
                        n_pend_valid = 1'b0;
                        n_state      = S_SCAN;
                    end
                    // drop the unused command code
                end
            end
            S_SCAN: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else if (scan_done) begin
                    if (r_cmd == CMD_REGISTER) begin
                        n_o_valid  = 1'b1;
                        n_o_kind   = KIND_STATUS;
                        n_o_handle = '0;
                        n_o_last   = 1'b1;
                        if (r_handle == '0) begin
                            n_o_status = ST_NULL;
                        end else if (tok_end.free_found) begin
                            n_o_status = ST_ACCEPTED;
                        end else begin
                            n_o_status = ST_FULL;
                        end
                        n_state = S_IDLE;
                    end else if (w_clr_en) begin
                        // hold the new find; the held one is now known not last
                        if (r_pend_valid) begin
                            n_o_valid  = 1'b1;
                            n_o_kind   = KIND_FIRED;
                            n_o_status = ST_ACCEPTED;
                            n_o_handle = r_pend_hdl;
                            n_o_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_hdl   = tok_end.exp_handle;
                        n_count      = r_count + 1'b1;
                        n_wait       = WW'(SLOTS);
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = ST_ACCEPTED;
                        n_o_last   = 1'b1;
                        if (r_pend_valid) begin
                            n_o_kind   = KIND_FIRED;
                            n_o_handle = r_pend_hdl;
                        end else begin
                            n_o_kind   = KIND_NONE;
                            n_o_handle = '0;
                        end
                        n_pend_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_wait       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_wait       <= n_wait;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_handle   <= n_handle;
        r_delay    <= n_delay;
        r_pend_hdl <= n_pend_hdl;
        r_o_kind   <= n_o_kind;
        r_o_status <= n_o_status;
        r_o_handle <= n_o_handle;
        r_o_last   <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tdata  = {6'd0, r_o_handle, r_o_status};
    assign o_m_axis_tlast  = r_o_last;

endmodule
